/* src/schroeder_allpass_filter_top_macros.svh */
// Assertion macros shared by the allpass filter RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef SCHROEDER_ALLPASS_FILTER_TOP_MACROS_SVH
`define SCHROEDER_ALLPASS_FILTER_TOP_MACROS_SVH

// Condition must hold at every edge out of reset.
`define SAP_AST_HOLD(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("%m: invariant violated");

// Same-cycle implication.
`define SAP_AST_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication violated");

// Next-cycle implication.
`define SAP_AST_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication violated");

`endif

/* src/sap_pkg.sv */
// Shared constants and types for the Schroeder allpass filter.
// No dependencies; used by the top level.
package sap_pkg;

	localparam int DELAY_DEPTH_DEF = 1024;
	localparam int SAMPLE_W        = 16;
	localparam int GAIN_W          = 16;
	localparam int DELAY_W         = 10;
	localparam int CFG_W           = 16;
	localparam int ACC_W           = 34;   // exact Q30 sum of three terms plus rounding
	localparam int YR_W            = ACC_W - 15;

	typedef enum logic [0:0] {
		REG_GAIN  = 1'b0,
		REG_DELAY = 1'b1
	} cfg_idx_t;

endpackage

/* src/sap_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first on an address collision. No dependencies.
module sap_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/schroeder_allpass_filter_top.sv */
// Schroeder allpass filter top level: y = -g*x + x[n-D] + g*y[n-D].
// Depends on sap_pkg, sap_ram and schroeder_allpass_filter_top_macros.svh.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+------------------------------
//   in       | in  | in_valid / in_stall  | sample_in  (s16)
//   out      | out | out_valid / out_stall| sample_out (s16, saturated)
//   cfg      | in  | cfg_we, cfg_index    | cfg_data   (gain, delay_samples)
//
// One beat per clock sustained while out_stall is low; each beat passes s1, s2
// and the out register. The rate is set by the output-history recurrence, which
// closes in stage 2 through one g*y multiply, the final add and the saturation.
// Reset clears control only; the two delay RAMs are not swept. A fill count
// marks which entries were written since reset, and unwritten entries read as 0.
// An out stall holds the output register; the front keeps taking beats until
// the two internal stages are also full.
`include "schroeder_allpass_filter_top_macros.svh"

module schroeder_allpass_filter_top #(
	parameter int DELAY_DEPTH = sap_pkg::DELAY_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input beat channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [sap_pkg::SAMPLE_W-1:0] sample_in,
	// output beat channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [sap_pkg::SAMPLE_W-1:0] sample_out,
	// configuration write port
	input  logic                                cfg_we,
	input  sap_pkg::cfg_idx_t                   cfg_index,
	input  logic [sap_pkg::CFG_W-1:0]           cfg_data
);

	// Address width, fill-count width, and a width that holds both the
	// pointer and the delay plus one bit for the wrap arithmetic.
	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int CW = $clog2(DELAY_DEPTH + 1);
	localparam int WW = ((AW > sap_pkg::DELAY_W) ? AW : sap_pkg::DELAY_W) + 1;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [sap_pkg::GAIN_W-1:0]  gain_q;
	logic        [sap_pkg::DELAY_W-1:0] delay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= '0;
			delay_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sap_pkg::REG_GAIN:  gain_q  <= signed'(cfg_data[sap_pkg::GAIN_W-1:0]);
				sap_pkg::REG_DELAY: delay_q <= cfg_data[sap_pkg::DELAY_W-1:0];
				default:            ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline handshake: s1 (RAM data back), s2 (recurrence), out register
	// ------------------------------------------------------------------
	logic v1_q, v2_q, out_valid_q;
	logic accept, en2, out_adv;

	assign out_adv  = v2_q & (~out_valid_q | ~out_stall);
	assign en2      = v1_q & (~v2_q | out_adv);
	assign in_stall = v1_q & ~en2;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v1_q        <= accept | (v1_q & ~en2);
			v2_q        <= en2 | (v2_q & ~out_adv);
			out_valid_q <= out_adv | (out_valid_q & out_stall);
		end
	end

	assign out_valid = out_valid_q;

	// ------------------------------------------------------------------
	// Write pointer, fill count and read address
	// ------------------------------------------------------------------
	logic [AW-1:0] wp_q;
	logic [CW-1:0] fill_q;
	logic [WW-1:0] d_ext, d_eff, depth_w, wp_ext, rp_ext;
	logic [AW-1:0] rd_addr;
	logic          d_zero, rd_valid;

	assign depth_w  = WW'(DELAY_DEPTH);
	assign d_ext    = WW'(delay_q);
	// delays past the store length clamp to the longest one
	assign d_eff    = (d_ext >= depth_w) ? depth_w - WW'(1) : d_ext;
	assign wp_ext   = WW'(wp_q);
	assign rp_ext   = (wp_ext >= d_eff) ? wp_ext - d_eff : wp_ext + depth_w - d_eff;
	assign rd_addr  = rp_ext[AW-1:0];
	assign d_zero   = (d_eff == '0);
	// entries are written in address order from reset, so anything at or
	// above the fill count has never been written and reads as zero
	assign rd_valid = (CW'(rd_addr) < fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (accept) begin
			wp_q <= (wp_q == AW'(DELAY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (fill_q != CW'(DELAY_DEPTH)) begin
				fill_q <= fill_q + CW'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Delay stores
	// ------------------------------------------------------------------
	logic [sap_pkg::SAMPLE_W-1:0]        xram_rd, yram_rd;
	logic signed [sap_pkg::SAMPLE_W-1:0] y_sat;
	logic [AW-1:0]                       wp_s1, wp_s2;
	logic                                ywe;

	assign ywe = out_adv;

	// past inputs: written with the new sample as it is accepted
	sap_ram #(
		.WIDTH (sap_pkg::SAMPLE_W),
		.DEPTH (DELAY_DEPTH)
	) u_xram (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_q),
		.wdata (sample_in),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (xram_rd)
	);

	// past outputs: written with the saturated result as it leaves stage 2
	sap_ram #(
		.WIDTH (sap_pkg::SAMPLE_W),
		.DEPTH (DELAY_DEPTH)
	) u_yram (
		.clk   (clk),
		.we    (ywe),
		.waddr (wp_s2),
		.wdata (y_sat),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (yram_rd)
	);

	// ------------------------------------------------------------------
	// Stage 1: RAM data back; build the feedforward part
	// ------------------------------------------------------------------
	logic signed [sap_pkg::SAMPLE_W-1:0] x_s1, hity_s1;
	logic [AW-1:0]                       rp_s1;
	logic                                fwd_x_s1, rdv_s1, hit_s1;
	logic                                snoop_now;

	// y write landing on this beat's read address after the RAM read was issued
	assign snoop_now = ywe & (wp_s2 == rp_s1);

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1     <= sample_in;
			wp_s1    <= wp_q;
			rp_s1    <= rd_addr;
			fwd_x_s1 <= d_zero;
			rdv_s1   <= rd_valid;
		end
	end

	// Snoop y writes between read issue and the move into stage 2; the RAM
	// is read-first, so a write at the accept edge is caught here too.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
		end else if (accept) begin
			hit_s1 <= ywe & (wp_s2 == rd_addr);
		end else if (v1_q & ~en2 & snoop_now) begin
			hit_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept | (v1_q & ~en2 & snoop_now)) begin
			hity_s1 <= y_sat;
		end
	end

	logic signed [sap_pkg::SAMPLE_W-1:0] xd, yd_sel;
	logic signed [2*sap_pkg::SAMPLE_W-1:0] prod_gx;
	logic signed [sap_pkg::ACC_W-1:0]    part;

	// zero delay: the x term is the sample itself
	assign xd      = fwd_x_s1 ? x_s1 : (rdv_s1 ? signed'(xram_rd) : '0);
	assign yd_sel  = snoop_now ? y_sat :
	                 hit_s1    ? hity_s1 :
	                 rdv_s1    ? signed'(yram_rd) : '0;
	assign prod_gx = gain_q * x_s1;
	// -g*x + x[n-D]*2^15 + half LSB for round-half-up
	assign part    = -sap_pkg::ACC_W'(prod_gx)
	               + (sap_pkg::ACC_W'(xd) <<< 15)
	               + sap_pkg::ACC_W'(16384);

	// ------------------------------------------------------------------
	// Stage 2: feedback product, sum, floor, saturate
	// ------------------------------------------------------------------
	logic signed [sap_pkg::ACC_W-1:0]      part_s2, acc;
	logic signed [sap_pkg::SAMPLE_W-1:0]   yd_s2;
	logic signed [2*sap_pkg::SAMPLE_W-1:0] prod_gy;
	logic signed [sap_pkg::YR_W-1:0]       yr;

	always_ff @(posedge clk) begin
		if (en2) begin
			part_s2 <= part;
			yd_s2   <= yd_sel;
			wp_s2   <= wp_s1;
		end
	end

	assign prod_gy = gain_q * yd_s2;
	assign acc     = part_s2 + sap_pkg::ACC_W'(prod_gy);
	assign yr      = acc[sap_pkg::ACC_W-1:15];   // floor by 2^15

	always_comb begin
		if (yr > sap_pkg::YR_W'(32767)) begin
			y_sat = 16'sh7FFF;
		end else if (yr < -sap_pkg::YR_W'(32768)) begin
			y_sat = 16'sh8000;
		end else begin
			y_sat = yr[sap_pkg::SAMPLE_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic signed [sap_pkg::SAMPLE_W-1:0] sample_out_q;

	always_ff @(posedge clk) begin
		if (out_adv) begin
			sample_out_q <= y_sat;
		end
	end

	assign sample_out = sample_out_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`SAP_AST_HOLD(a_fill_bound, clk, arst_n, fill_q <= CW'(DELAY_DEPTH))
	`SAP_AST_NXT(a_wp_moves, clk, arst_n, accept, wp_q != $past(wp_q))
	`SAP_AST_NXT(a_out_loaded, clk, arst_n, out_adv, out_valid_q)
	`SAP_AST_NXT(a_snoop_held, clk, arst_n, v1_q && !en2 && snoop_now, hit_s1 && (hity_s1 == $past(y_sat)))
	`SAP_AST_IMP(a_fwd_same_addr, clk, arst_n, v1_q && fwd_x_s1, rp_s1 == wp_s1)

endmodule
